### src/ksa_pkg.sv
// Package for the keyed score accumulator: request and status codes, FSM states.
// No dependencies.
package ksa_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_NEW  = 3'd0,
    ST_ACC  = 3'd1,
    ST_FULL = 3'd2,
    ST_RANK = 3'd3,
    ST_NONE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_SCAN,
    S_ADD_WAIT,
    S_ADD_DONE,
    S_FIN_SCAN,
    S_FIN_WAIT,
    S_FIN_PICK,
    S_FIN_DUP,
    S_FIN_DUPW,
    S_FIN_EMIT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;     // capture input request
    logic scan_start;   // zero scan index and search results
    logic scan_step;    // issue read of current index, advance
    logic add_acc;      // write accumulated score to found slot
    logic add_new;      // append new entry
    logic do_clear;     // empty table
    logic taken_clear;  // clear taken flags
    logic fin_start;    // zero emitted count
    logic take_best;    // mark best taken, count it as emitted
    logic dup_mark;     // set duplicate flag
    logic emit;         // load output register with ranked result
    logic resp;         // load output register with simple result
    logic [2:0] resp_status;
  } ksa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;    // current issue index is the last entry
    logic found;        // add search matched
    logic full;
    logic best_found;
    logic want_done;    // emitted count reached limit
    logic any_emitted;
    logic dup_hit;      // registered compare hit during dup scan
    logic out_busy;     // output register holds an undelivered result
  } ksa_stat_t;

endpackage

### src/ksa_ctrl.sv
// Controller FSM for the keyed score accumulator.
// Depends on ksa_pkg.
module ksa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        req_type,
  output logic              in_stall,
  input  ksa_pkg::ksa_stat_t st,
  output ksa_pkg::ksa_cmd_t  cmd
);

  ksa_pkg::state_t state, state_next;
  logic [1:0] req, req_next;
  logic       dup_scan, dup_scan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksa_pkg::S_IDLE;
      req <= ksa_pkg::REQ_NOP;
      dup_scan <= 1'b0;
    end else begin
      state <= state_next;
      req <= req_next;
      dup_scan <= dup_scan_next;
    end
  end

  always_comb begin
    state_next = state;
    req_next = req;
    dup_scan_next = dup_scan;
    cmd = '0;
    cmd.resp_status = ksa_pkg::ST_NONE;
    in_stall = 1'b1;
    unique case (state)
      ksa_pkg::S_IDLE: begin
        in_stall = st.out_busy;
        if (in_valid && !st.out_busy) begin
          cmd.load_req = 1'b1;
          req_next = req_type;
          unique case (req_type)
            ksa_pkg::REQ_ADD: begin
              cmd.scan_start = 1'b1;
              state_next = ksa_pkg::S_ADD_SCAN;
            end
            ksa_pkg::REQ_FINISH: begin
              cmd.fin_start = 1'b1;
              cmd.taken_clear = 1'b1;
              state_next = ksa_pkg::S_FIN_PICK;
            end
            default: state_next = ksa_pkg::S_RESP;
          endcase
        end
      end
      ksa_pkg::S_ADD_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = ksa_pkg::S_ADD_WAIT;
      end
      ksa_pkg::S_ADD_WAIT: state_next = ksa_pkg::S_ADD_DONE;
      ksa_pkg::S_ADD_DONE: begin
        if (!st.out_busy) begin
          cmd.resp = 1'b1;
          if (st.found) begin
            cmd.add_acc = 1'b1;
            cmd.resp_status = ksa_pkg::ST_ACC;
          end else if (st.full) begin
            cmd.resp_status = ksa_pkg::ST_FULL;
          end else begin
            cmd.add_new = 1'b1;
            cmd.resp_status = ksa_pkg::ST_NEW;
          end
          state_next = ksa_pkg::S_IDLE;
        end
      end
      ksa_pkg::S_FIN_PICK: begin
        if (st.want_done) begin
          if (!st.any_emitted) state_next = ksa_pkg::S_RESP;
          else state_next = ksa_pkg::S_IDLE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = ksa_pkg::S_FIN_SCAN;
        end
      end
      ksa_pkg::S_FIN_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = ksa_pkg::S_FIN_WAIT;
      end
      ksa_pkg::S_FIN_WAIT: begin
        if (dup_scan) state_next = ksa_pkg::S_FIN_DUPW;
        else state_next = ksa_pkg::S_FIN_DUP;
      end
      ksa_pkg::S_FIN_DUP: begin
        // max search result is complete here, last row included
        if (!st.best_found) begin
          state_next = st.any_emitted ? ksa_pkg::S_IDLE : ksa_pkg::S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          dup_scan_next = 1'b1;
          state_next = ksa_pkg::S_FIN_SCAN;
        end
      end
      ksa_pkg::S_FIN_DUPW: begin
        if (st.dup_hit) cmd.dup_mark = 1'b1;
        state_next = ksa_pkg::S_FIN_EMIT;
      end
      ksa_pkg::S_FIN_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          cmd.take_best = 1'b1;
          dup_scan_next = 1'b0;
          state_next = ksa_pkg::S_FIN_PICK;
        end
      end
      ksa_pkg::S_RESP: begin
        if (!st.out_busy) begin
          cmd.resp = 1'b1;
          cmd.resp_status = ksa_pkg::ST_NONE;
          if (req == ksa_pkg::REQ_CLEAR) begin
            cmd.do_clear = 1'b1;
            cmd.taken_clear = 1'b1;
          end
          state_next = ksa_pkg::S_IDLE;
        end
      end
      default: state_next = ksa_pkg::S_IDLE;
    endcase
  end

endmodule

### src/ksa_dp.sv
// Datapath for the keyed score accumulator: entry memory, scan unit, output register.
// Depends on ksa_pkg.
module ksa_dp #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_TOP = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ksa_pkg::ksa_cmd_t  cmd,
  output ksa_pkg::ksa_stat_t st,
  input  logic [4:0]         top_count,
  input  logic [15:0]        group_id,
  input  logic [15:0]        item_id,
  input  logic signed [31:0] score_delta,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         status,
  output logic [15:0]        out_item_id,
  output logic signed [31:0] out_score,
  output logic               duplicate,
  output logic               last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int TW = $clog2(MAX_TOP + 1);
  localparam int LW = (CW > TW) ? CW : TW;

  logic [15:0]        mem_group [TABLE_ENTRIES];
  logic [15:0]        mem_item  [TABLE_ENTRIES];
  logic signed [31:0] mem_score [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] taken;

  logic [15:0]        q_group, q_item;
  logic signed [31:0] q_delta;
  logic [CW-1:0]      count;
  logic [IW-1:0]      idx, rd_idx;
  logic               rd_valid;
  logic [15:0]        rd_group, rd_item;
  logic signed [31:0] rd_score;
  logic               found;
  logic [IW-1:0]      found_idx;
  logic signed [31:0] found_score;
  logic               best_found;
  logic [IW-1:0]      best_idx;
  logic signed [31:0] best_score;
  logic [15:0]        best_item;
  logic               dup_hit, dup_flag;
  logic [TW-1:0]      emitted;
  logic [TW-1:0]      want;
  logic signed [32:0] sum;
  logic signed [31:0] sat;
  logic               row_live;

  assign want = (int'(top_count) > MAX_TOP) ? TW'(MAX_TOP) : TW'(top_count);
  assign row_live = rd_valid && ({1'b0, rd_idx} < (IW+1)'(count));

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      q_group <= group_id;
      q_item <= item_id;
      q_delta <= score_delta;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk) begin
    rd_group <= mem_group[idx];
    rd_item  <= mem_item[idx];
    rd_score <= mem_score[idx];
    rd_idx   <= idx;
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (cmd.add_acc) begin
      mem_score[found_idx] <= sat;
    end else if (cmd.add_new) begin
      mem_group[count[IW-1:0]] <= q_group;
      mem_item[count[IW-1:0]]  <= q_item;
      mem_score[count[IW-1:0]] <= q_delta;
    end
  end

  always_comb begin
    sum = 33'(found_score) + 33'(q_delta);
    if (sum > 33'sd2147483647) sat = 32'sh7fffffff;
    else if (sum < -33'sd2147483648) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      taken <= '0;
      idx <= '0;
      rd_valid <= 1'b0;
      found <= 1'b0;
      best_found <= 1'b0;
      dup_hit <= 1'b0;
      dup_flag <= 1'b0;
      emitted <= '0;
    end else begin
      rd_valid <= cmd.scan_step;
      if (cmd.scan_start) begin
        idx <= '0;
        found <= 1'b0;
        dup_hit <= 1'b0;
      end else if (cmd.scan_step) begin
        idx <= idx + IW'(1);
      end
      if (cmd.fin_start) begin
        emitted <= '0;
        best_found <= 1'b0;
        dup_flag <= 1'b0;
      end
      // add search: hold index of match for final read-modify-write
      if (row_live && rd_group == q_group && rd_item == q_item && !found) begin
        found <= 1'b1;
        found_idx <= rd_idx;
      end
      // max search (strict >, earliest wins) when not in dup pass
      if (row_live && !taken[rd_idx] && !dup_flag) begin
        if (!best_found || rd_score > best_score) begin
          best_found <= 1'b1;
          best_idx <= rd_idx;
          best_score <= rd_score;
          best_item <= rd_item;
        end
      end
      // dup pass
      if (row_live && dup_flag && taken[rd_idx] && rd_item == best_item) dup_hit <= 1'b1;
      if (cmd.dup_mark) dup_hit <= 1'b1;
      if (cmd.scan_start && best_found && !cmd.fin_start && !dup_flag) begin
        dup_flag <= 1'b1;
      end
      if (cmd.take_best) begin
        taken[best_idx] <= 1'b1;
        emitted <= emitted + TW'(1);
        best_found <= 1'b0;
        dup_flag <= 1'b0;
      end
      if (cmd.taken_clear) taken <= '0;
      if (cmd.add_new) count <= count + CW'(1);
      if (cmd.do_clear) count <= '0;
    end
  end

  // score of the matching entry, for the accumulate write
  always_ff @(posedge clk) begin
    if (row_live && rd_group == q_group && rd_item == q_item && !found) found_score <= rd_score;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.resp) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= ksa_pkg::ST_RANK;
      out_item_id <= best_item;
      out_score <= best_score;
      duplicate <= dup_hit;
      last <= (LW'(emitted) + LW'(1) == LW'(want)) ||
              (LW'(emitted) + LW'(1) == LW'(count));
    end else if (cmd.resp) begin
      status <= cmd.resp_status;
      out_item_id <= '0;
      out_score <= '0;
      duplicate <= 1'b0;
      last <= 1'b1;
    end
  end

  always_comb begin
    st.scan_last = (idx == IW'(TABLE_ENTRIES - 1));
    st.found = found;
    st.full = (count == CW'(TABLE_ENTRIES));
    st.best_found = best_found;
    st.want_done = (emitted >= want) || (LW'(emitted) >= LW'(count));
    st.any_emitted = (emitted != '0);
    st.dup_hit = dup_hit;
    st.out_busy = out_valid && out_stall;
  end

endmodule

### src/keyed_score_accumulator_top_k_unit.sv
// Channel   Signals                                               Direction
// request   in_valid, in_stall, req_type, group_id, item_id, score_delta   in
// result    out_valid, out_stall, status, out_item_id, out_score, duplicate, last  out
// config    cfg_we, cfg_data (top_count)                           in
//
// Add: one scan over the whole entry memory, then a write unless the table is full.
// Finish: per ranked result one max scan and one duplicate scan of the memory.
// Clear and no-op: no scan, straight to the response.
// Reset clears table count and taken flags and sets top_count to 16. Output stall holds the
// result register; a new request is taken only after the result register is free.
// Top level; depends on ksa_pkg, ksa_ctrl, ksa_dp.
module keyed_score_accumulator_top_k_unit #(
  parameter int TABLE_ENTRIES = 64,
  parameter int MAX_TOP = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [15:0]        group_id,
  input  logic [15:0]        item_id,
  input  logic signed [31:0] score_delta,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [15:0]        out_item_id,
  output logic signed [31:0] out_score,
  output logic               duplicate,
  output logic               last,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data
);

  logic [4:0] top_count;
  ksa_pkg::ksa_cmd_t  cmd;
  ksa_pkg::ksa_stat_t st;

  always_ff @(posedge clk) begin
    if (rst) top_count <= 5'd16;
    else if (cfg_we) top_count <= cfg_data;
  end

  ksa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .req_type(req_type),
    .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  ksa_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_TOP(MAX_TOP)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .top_count(top_count),
    .group_id(group_id), .item_id(item_id), .score_delta(score_delta),
    .out_stall(out_stall), .out_valid(out_valid), .status(status),
    .out_item_id(out_item_id), .out_score(out_score), .duplicate(duplicate),
    .last(last)
  );

  a_emit_one: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit && cmd.resp)) else $error("emit and resp together");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !out_valid || !out_stall) else $error("accepted while busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && status != ksa_pkg::ST_RANK) |-> last)
    else $error("non-ranked result without last");

endmodule

### sim/keyed_score_accumulator_top_k_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for keyed_score_accumulator_top_k_unit: directed and random add, finish, clear and
// no-op requests with a scoreboard fed by an in-bench score table. Depends on ksa_pkg.
module keyed_score_accumulator_top_k_unit_tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int MAX_TOP = 16;

  typedef struct packed {
    ksa_pkg::status_t   st;
    logic [15:0]        item;
    logic signed [31:0] score;
    logic               dup;
    logic               lst;
  } result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [1:0] req_type = 0;
  logic [15:0] group_id = 0, item_id = 0;
  logic signed [31:0] score_delta = 0;
  logic out_valid, out_stall = 0;
  logic [2:0] status;
  logic [15:0] out_item_id;
  logic signed [31:0] out_score;
  logic duplicate, last;
  logic cfg_we = 0;
  logic [4:0] cfg_data = 0;

  keyed_score_accumulator_top_k_unit #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_TOP(MAX_TOP)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .group_id(group_id), .item_id(item_id), .score_delta(score_delta),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .out_item_id(out_item_id), .out_score(out_score), .duplicate(duplicate), .last(last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // shadow table
  logic               tbl_valid [TABLE_ENTRIES];
  logic [15:0]        tbl_group [TABLE_ENTRIES];
  logic [15:0]        tbl_item  [TABLE_ENTRIES];
  logic signed [31:0] tbl_score [TABLE_ENTRIES];
  int                 tbl_count;
  logic [4:0]         top_count;

  result_t pending_results[$];
  int errors = 0, requests_sent = 0, results_seen = 0, ranked_seen = 0;
  bit idle_on = 1;

  function automatic void queue_result(result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic result_t mk(ksa_pkg::status_t st);
    result_t r;
    r = '0;
    r.st = st;
    r.lst = 1;
    return r;
  endfunction

  task automatic predict_request(logic [1:0] rt, logic [15:0] g, logic [15:0] it,
                                 logic signed [31:0] d);
    int want, n, best;
    bit hit;
    logic taken [TABLE_ENTRIES];
    result_t r;
    hit = 0;
    n = 0;
    if (rt == ksa_pkg::REQ_ADD) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (!hit && tbl_valid[i] && tbl_group[i] == g && tbl_item[i] == it) begin
          tbl_score[i] = sat_sum(tbl_score[i], d);
          hit = 1;
        end
      if (hit) queue_result(mk(ksa_pkg::ST_ACC));
      else if (tbl_count < TABLE_ENTRIES) begin
        tbl_valid[tbl_count] = 1;
        tbl_group[tbl_count] = g;
        tbl_item[tbl_count] = it;
        tbl_score[tbl_count] = d;
        tbl_count++;
        queue_result(mk(ksa_pkg::ST_NEW));
      end else queue_result(mk(ksa_pkg::ST_FULL));
    end else if (rt == ksa_pkg::REQ_FINISH) begin
      want = (top_count > MAX_TOP) ? MAX_TOP : top_count;
      foreach (taken[i]) taken[i] = 0;
      for (int k = 0; k < want; k++) begin
        best = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (tbl_valid[i] && !taken[i] && (best < 0 || tbl_score[i] > tbl_score[best]))
            best = i;
        if (best < 0) break;
        r = '0;
        r.st = ksa_pkg::ST_RANK;
        r.item = tbl_item[best];
        r.score = tbl_score[best];
        for (int j = 0; j < TABLE_ENTRIES; j++)
          if (taken[j] && tbl_item[j] == tbl_item[best]) r.dup = 1;
        taken[best] = 1;
        queue_result(r);
        n++;
      end
      if (n == 0) queue_result(mk(ksa_pkg::ST_NONE));
      else pending_results[$].lst = 1;
    end else begin
      if (rt == ksa_pkg::REQ_CLEAR) begin
        foreach (tbl_valid[i]) tbl_valid[i] = 0;
        tbl_count = 0;
      end
      queue_result(mk(ksa_pkg::ST_NONE));
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_v);
    errors++;
  endtask

  task automatic send_request(logic [1:0] rt, logic [15:0] g, logic [15:0] it,
                              logic signed [31:0] d);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
    else @(negedge clk);
    req_type <= rt;
    group_id <= g;
    item_id <= it;
    score_delta <= d;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(rt, g, it, d);
    requests_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
  endtask

  task automatic set_top_count(logic [4:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1;
    @(negedge clk);
    cfg_we <= 0;
    top_count = v;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'(0));
      end else begin
        e = pending_results.pop_front();
        if (status == ksa_pkg::ST_RANK) ranked_seen++;
        if (status != e.st) report_mismatch("status", 32'(status), 32'(e.st));
        if (out_item_id != e.item) report_mismatch("out_item_id", 32'(out_item_id), 32'(e.item));
        if (out_score != e.score) report_mismatch("out_score", out_score, e.score);
        if (duplicate != e.dup) report_mismatch("duplicate", 32'(duplicate), 32'(e.dup));
        if (last != e.lst) report_mismatch("last", 32'(last), 32'(e.lst));
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic test_extremes();
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
    send_request(ksa_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF);
    send_request(ksa_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF, 32'sh00000100);
    send_request(ksa_pkg::REQ_ADD, 16'h0000, 16'h0000, 32'sh80000000);
    send_request(ksa_pkg::REQ_ADD, 16'h0000, 16'h0000, -32'sd5);
    send_request(ksa_pkg::REQ_ADD, 16'h0001, 16'hFFFF, 32'sh00010000);
    send_request(ksa_pkg::REQ_ADD, 16'h0002, 16'h0007, 32'sh00010000);
    send_request(ksa_pkg::REQ_ADD, 16'h0003, 16'h0007, 32'sh00010000);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
    send_request(ksa_pkg::REQ_NOP, 16'hFFFF, 16'hFFFF, -32'sd1);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
    send_request(ksa_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'sd0);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
  endtask

  task automatic test_top_counts();
    for (int i = 0; i < 6; i++)
      send_request(ksa_pkg::REQ_ADD, 16'd5, 16'(i), 32'($urandom_range(0, 3) << 16));
    set_top_count(5'd0);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
    set_top_count(5'd31);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
    set_top_count(5'd3);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
  endtask

  task automatic test_table_full();
    send_request(ksa_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'sd0);
    for (int i = 0; i < TABLE_ENTRIES + 2; i++)
      send_request(ksa_pkg::REQ_ADD, 16'(i), 16'(i[2:0]), $urandom);
    send_request(ksa_pkg::REQ_ADD, 16'd0, 16'd0, 32'sd1);
    set_top_count(5'd16);
    send_request(ksa_pkg::REQ_FINISH, 16'd0, 16'd0, 32'sd0);
  endtask

  task automatic test_random(int n);
    int r;
    logic signed [31:0] d;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if (i == n - 30) idle_on = 0;
      r = $urandom_range(0, 99);
      d = ($urandom_range(0, 9) == 0) ? $urandom
                                      : $signed($urandom_range(0, 8) << 14) - 32'sh10000;
      if (r < 75)
        send_request(ksa_pkg::REQ_ADD, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 5)), d);
      else if (r < 88)
        send_request(ksa_pkg::REQ_FINISH, 16'($urandom), 16'($urandom), $urandom);
      else if (r < 92)
        send_request(ksa_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom), $urandom);
      else if (r < 95)
        send_request(ksa_pkg::REQ_NOP, 16'($urandom), 16'($urandom), $urandom);
      else send_request(ksa_pkg::REQ_ADD, 16'($urandom), 16'($urandom), $urandom);
      if (r == 50) set_top_count(5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    tbl_count = 0;
    top_count = 16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_extremes();
    test_top_counts();
    test_table_full();
    send_request(ksa_pkg::REQ_CLEAR, 16'd0, 16'd0, 32'sd0);
    set_top_count(5'd16);
    test_random(78);
    drain();
    $display("Sent %0d requests, checked %0d results (%0d ranked entries)",
             requests_sent, results_seen, ranked_seen);
    $display("Covered adds, saturation, full table, finish at top counts 0..31, clear, no-op.");
    if (errors == 0 && pending_results.size() == 0)
      $display("** keyed_score_accumulator_top_k_unit: PASSED **");
    else $display("** keyed_score_accumulator_top_k_unit: FAILED **");
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("** keyed_score_accumulator_top_k_unit: FAILED **");
    $finish;
  end
endmodule
